// ----- hw/rtl/sha256_pkg.sv -----
// ----------------------------------------------------------------------------
// SHA-256 package
// Round constants, initial hash values, functions and shared types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package sha256_pkg;

  localparam int unsigned ROUNDS = 64;

  typedef logic [31:0] word_t;

  // Request handed from the front end to the compression engine.
  typedef struct packed {
    logic       fin;      // finish: pad, length and digest
    logic [7:0] data;
  } req_t;

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ROUND, ST_ADD, ST_PAD, ST_OUT
  } eng_state_t;

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t ssig0(input word_t x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t ssig1(input word_t x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t bsig0(input word_t x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t bsig1(input word_t x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/sha256_fifo.sv -----
// ----------------------------------------------------------------------------
// SHA-256 request queue
// Small FIFO that decouples request intake from the compression engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module sha256_fifo
  import sha256_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr_valid,
  output logic      wr_ready,
  input  wire req_t wr_data,
  output logic      rd_valid,
  input  wire logic rd_ready,
  output req_t      rd_data
);

  req_t       mem_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;
  logic       wr_en, rd_en;

  assign wr_ready = (cnt_r != 3'd4);
  assign rd_valid = (cnt_r != 3'd0);
  assign rd_data  = mem_r[rp_r];
  assign wr_en    = wr_valid && wr_ready;
  assign rd_en    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 2'd1;
      if (rd_en) rp_r <= rp_r + 2'd1;
      if (wr_en && !rd_en) cnt_r <= cnt_r + 3'd1;
      else if (rd_en && !wr_en) cnt_r <= cnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

endmodule
`default_nettype wire

// ----- hw/rtl/sha256_engine.sv -----
// ----------------------------------------------------------------------------
// SHA-256 engine
// Byte packing, padding, 64-round compression (one round per cycle), digest.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module sha256_engine
  import sha256_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        req_valid,
  output logic             req_ready,
  input  wire req_t        req,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_word,
  output logic [2:0]       out_idx
);

  eng_state_t  state_r, state_nxt;
  word_t       h_r [8];
  word_t       v_r [8];
  word_t       w_r [16];     // message schedule window, w_r[0] is current word
  logic [5:0]  fill_r;
  logic [63:0] blen_r;
  logic [63:0] total_r;
  logic [5:0]  rnd_r;
  logic        fin_r;        // compressing as part of a finish
  logic        lenblk_r;     // current block carries the length
  logic [2:0]  oidx_r;
  logic [31:0] pack_r;       // partial word being assembled

  word_t t1, t2, wn;

  always_comb begin
    t1 = v_r[7] + bsig1(v_r[4]) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
         + ROUND_K[rnd_r] + w_r[0];
    t2 = bsig0(v_r[0]) + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
    wn = ssig1(w_r[14]) + w_r[9] + ssig0(w_r[1]) + w_r[0];
  end

  assign req_ready = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign out_word  = h_r[oidx_r];
  assign out_idx   = oidx_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (req_valid) begin
          // pad byte in the last slot fills the block: compress it at once
          if (req.fin) state_nxt = (fill_r == 6'd63) ? ST_ROUND : ST_PAD;
          else if (fill_r == 6'd63) state_nxt = ST_ROUND;
        end
      end
      ST_PAD:   if (fill_r == 6'd63) state_nxt = ST_ROUND;
      ST_ROUND: if (rnd_r == 6'd63) state_nxt = ST_ADD;
      ST_ADD: begin
        if (!fin_r) state_nxt = ST_IDLE;
        else if (lenblk_r) state_nxt = ST_OUT;
        else state_nxt = ST_PAD;
      end
      ST_OUT:   if (out_ready && oidx_r == 3'd7) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // Push one byte into the schedule window at position fill_r.
  logic       push;
  logic [7:0] pbyte;
  always_comb begin
    push  = 1'b0;
    pbyte = req.data;
    if (state_r == ST_IDLE && req_valid && !req.fin) push = 1'b1;
    if (state_r == ST_PAD) begin
      push = 1'b1;
      if (fill_r >= LEN_POS && lenblk_r)
        pbyte = total_r[8*(7 - fill_r[2:0]) +: 8];
      else if (fill_r == 6'd0 && !lenblk_r && !fin_r)
        pbyte = PAD_BYTE;
      else
        pbyte = 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= '0;
      blen_r   <= '0;
      rnd_r    <= '0;
      fin_r    <= 1'b0;
      lenblk_r <= 1'b0;
      oidx_r   <= '0;
      for (int i = 0; i < 8; i++) h_r[i] <= INIT_H[i];
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (req_valid && req.fin) begin
            // pad byte goes in now; decide whether length fits this block
            total_r  <= blen_r + {55'd0, fill_r, 3'd0};
            fin_r    <= 1'b1;
            lenblk_r <= (fill_r < 6'd56);
          end
        end
        ST_ADD: begin
          for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
          if (!fin_r) blen_r <= blen_r + 64'd512;
          else if (!lenblk_r) lenblk_r <= 1'b1;
        end
        ST_OUT: begin
          if (out_ready) begin
            oidx_r <= oidx_r + 3'd1;
            if (oidx_r == 3'd7) begin
              for (int i = 0; i < 8; i++) h_r[i] <= INIT_H[i];
              blen_r   <= '0;
              fin_r    <= 1'b0;
              lenblk_r <= 1'b0;
            end
          end
        end
        default: ;
      endcase
      if (state_r == ST_ROUND) rnd_r <= rnd_r + 6'd1;
      if (state_r == ST_IDLE && req_valid && req.fin) begin
        fill_r <= fill_r + 6'd1;
      end else if (push) begin
        fill_r <= fill_r + 6'd1;
      end
    end
  end

  // Schedule window and working variables (payload, no reset).
  logic [31:0] word_in;
  always_comb begin
    word_in = {pack_r[23:0], pbyte};
    if (state_r == ST_IDLE && req_valid && req.fin)
      word_in = {pack_r[23:0], PAD_BYTE};
  end

  always_ff @(posedge clk) begin
    if ((push || (state_r == ST_IDLE && req_valid && req.fin))) begin
      pack_r <= word_in;
      if (fill_r[1:0] == 2'd3) w_r[fill_r[5:2]] <= word_in;
      if (fill_r == 6'd63)
        for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
    end
    if (state_r == ST_ROUND) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= wn;
      v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/sha256_stream_hasher.sv -----
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Streaming SHA-256 over a byte stream with an explicit finish request.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_*: each request carries in_tuser (func) and in_tdata
//   (data_byte). func 0 absorbs the byte, func 1 finishes the message.
//   Output channel out_*: after a finish, eight requests carry the digest,
//   word 0 first; out_tlast marks the eighth word.
// Timing:
//   A data byte is absorbed into the current block; the 64th byte of a block
//   starts the compression: the rounds and then one chaining add,
//   one SHA-256 round per cycle in a single shared round unit.
//   Finish writes the pad and length bytes one per cycle, compresses one
//   or two blocks, then offers eight digest words. A four-entry request
//   queue in front absorbs bytes while the engine compresses.
// Reset:
//   rst_n low clears the queue, returns the chaining words to the initial
//   hash values and zeroes the byte count and bit length.
// Stall:
//   While out_tready is low the current digest word holds and the engine
//   waits; the queue keeps taking requests until it is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module sha256_stream_hasher
  import sha256_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tuser,   // [0] func
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // [31:0] digest_word, [34:32] word_index
  output logic             out_tlast
);

  req_t q_in, q_out;
  logic q_valid, q_ready;
  logic [31:0] word;
  logic [2:0]  idx;

  assign q_in.fin  = in_tuser;
  assign q_in.data = in_tdata;

  sha256_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (in_tvalid),
    .wr_ready (in_tready),
    .wr_data  (q_in),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_out)
  );

  sha256_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (q_valid),
    .req_ready (q_ready),
    .req       (q_out),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_word  (word),
    .out_idx   (idx)
  );

  assign out_tdata = {5'd0, idx, word};
  assign out_tlast = (idx == 3'd7);

endmodule
`default_nettype wire
